### hw/rtl/clock_seven_segment_scanner_unit_assert.svh
// Assertion macros for the RTL. Empty in synthesis builds.
`ifndef CLOCK_SEVEN_SEGMENT_SCANNER_UNIT_ASSERT_SVH
`define CLOCK_SEVEN_SEGMENT_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CLKSEG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clkseg same-cycle check failed");
`define CLKSEG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clkseg next-cycle check failed");
`else
`define CLKSEG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CLKSEG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/clkseg_pkg.sv
`default_nettype none
package clkseg_pkg;

  localparam int unsigned NUM_DIGITS = 4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  localparam logic [6:0] HOUR_UNKNOWN = 7'd88;
  localparam logic [6:0] HOUR_NOON    = 7'd12;
  localparam logic [6:0] HOUR_MIDNIGHT = 7'd0;
  localparam logic [3:0] DIGIT_ZERO   = 4'd0;

  // bit0 = a .. bit6 = g
  localparam logic [6:0] SEG_TABLE [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef logic [NUM_DIGITS-1:0][3:0] digit_row_t;

  typedef struct packed {
    logic       operation;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic       link_up;
    logic       mode_24h;
  } req_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [3:0] digit_enable;
    logic       pm_lamp;
    logic       beep_start;
  } rsp_t;

  typedef struct packed {
    digit_row_t digits;
    logic       pm;
  } upd_t;

  // Divide by ten through a reciprocal; exact for every 7-bit value.
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [17:0] prod;
    prod = 18'(v) * 18'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] rem;
    rem = v - 7'(div10(v)) * 7'd10;
    return rem[3:0];
  endfunction

  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] g;
    g = 7'd0;
    if (d < 4'd10) begin
      g = SEG_TABLE[d];
    end
    return g;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/clkseg_ifs.sv
`default_nettype none
interface clkseg_req_if;
  import clkseg_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface clkseg_rsp_if;
  import clkseg_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/clkseg_time_split.sv
`default_nettype none
module clkseg_time_split (
  input  wire logic [6:0]      hours,
  input  wire logic [6:0]      minutes,
  input  wire logic            link_up,
  input  wire logic            mode_24h,
  input  wire logic            pm_cur,
  output clkseg_pkg::upd_t     upd
);
  import clkseg_pkg::*;

  logic [6:0] disp;
  logic       pm;

  // Convert for 12-hour display only when the link is up and the hour is known.
  always_comb begin
    disp = hours;
    pm   = pm_cur;
    if (link_up && hours != HOUR_UNKNOWN) begin
      if (mode_24h || hours < HOUR_NOON) begin
        if (hours == HOUR_MIDNIGHT && !mode_24h) begin
          disp = HOUR_NOON;
        end
        pm = 1'b0;
      end else begin
        if (hours != HOUR_NOON) begin
          disp = hours - HOUR_NOON;
        end
        pm = 1'b1;
      end
    end
  end

  always_comb begin
    upd.digits[0] = div10(disp);
    upd.digits[1] = mod10(disp);
    upd.digits[2] = div10(minutes);
    upd.digits[3] = mod10(minutes);
    upd.pm        = pm;
  end

endmodule
`default_nettype wire

### hw/rtl/clock_seven_segment_scanner_unit.sv
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register and the result register
// advance together, so ready only drops while a result waits and the input is full.
// Reset (rst, synchronous): clears scan phase, digits, last hour, PM lamp and the
// driven segment/digit values, and empties both registers.
`default_nettype none
`include "clock_seven_segment_scanner_unit_assert.svh"
module clock_seven_segment_scanner_unit (
  input wire logic    clk,
  input wire logic    rst,
  clkseg_req_if.sink  req,
  clkseg_rsp_if.source rsp
);
  import clkseg_pkg::*;

  logic       s1_valid;
  req_t       s1_req;
  logic       rsp_valid;
  logic       advance;

  logic [1:0] scan_phase;
  digit_row_t digit_store;
  logic [6:0] last_hour;
  logic       pm_state;
  logic [6:0] drive_segments;
  logic [3:0] drive_digit;
  logic       beep;

  logic [3:0] cur_digit;
  upd_t       upd;

  clkseg_time_split u_split (
    .hours    (s1_req.hours),
    .minutes  (s1_req.minutes),
    .link_up  (s1_req.link_up),
    .mode_24h (s1_req.mode_24h),
    .pm_cur   (pm_state),
    .upd      (upd)
  );

  assign advance   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign cur_digit = digit_store[scan_phase];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // State and the held result change only when a request moves to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase     <= 2'd0;
      digit_store    <= '0;
      last_hour      <= 7'd0;
      pm_state       <= 1'b0;
      drive_segments <= 7'd0;
      drive_digit    <= 4'd0;
      beep           <= 1'b0;
    end else if (advance) begin
      if (s1_req.operation == OP_UPDATE) begin
        digit_store <= upd.digits;
        pm_state    <= upd.pm;
        last_hour   <= s1_req.hours;
        beep        <= (s1_req.hours != last_hour);
      end else begin
        beep <= 1'b0;
        // Blank a leading zero on the leftmost digit.
        if (scan_phase == 2'd0 && cur_digit == DIGIT_ZERO) begin
          drive_digit    <= 4'd0;
          drive_segments <= 7'd0;
        end else begin
          drive_digit    <= 4'd1 << scan_phase;
          drive_segments <= glyph(cur_digit);
        end
        scan_phase <= scan_phase + 2'd1;
      end
    end
  end

  assign rsp.valid                = rsp_valid;
  assign rsp.payload.segments     = drive_segments;
  assign rsp.payload.digit_enable = drive_digit;
  assign rsp.payload.pm_lamp      = pm_state;
  assign rsp.payload.beep_start   = beep;

  `CLKSEG_ASSERT_SAME(a_digit_onehot, clk, rst, rsp_valid, $onehot0(drive_digit))
  `CLKSEG_ASSERT_NEXT(a_scan_no_beep, clk, rst,
    advance && s1_req.operation == OP_SCAN, !beep)
  `CLKSEG_ASSERT_NEXT(a_scan_steps, clk, rst,
    advance && s1_req.operation == OP_SCAN, scan_phase == 2'($past(scan_phase) + 2'd1))
  `CLKSEG_ASSERT_NEXT(a_update_holds_phase, clk, rst,
    advance && s1_req.operation == OP_UPDATE, $stable(scan_phase))

endmodule
`default_nettype wire
